/* rtl/afrp_pkg.sv */
// Shared types and constants for the API frame receive parser.
package afrp_pkg;

    localparam logic [7:0] START_BYTE  = 8'h7E;
    localparam logic [7:0] STATUS_TYPE = 8'h89;
    localparam logic [7:0] SUM_BASE    = 8'hFF;
    localparam int unsigned HEADER_LEN = 7;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BCAST_ADDR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HUNT_LIMIT = 2'd2;

    localparam logic [7:0] OWN_ADDR_RESET   = 8'd0;
    localparam logic [7:0] BCAST_ADDR_RESET = 8'd255;
    localparam logic [7:0] HUNT_LIMIT_RESET = 8'd6;

    localparam int unsigned TDATA_W = 96;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_LENGTH   = 2'd2,
        ST_NOSTART  = 2'd3
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_REPORT  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [7:0]  instruction;
        logic [7:0]  slave_address;
        logic [15:0] source_address;
        logic [7:0]  rssi;
        logic [7:0]  options;
        logic        addressed_to_me;
        logic [15:0] good_frames;
        logic [15:0] error_frames;
    } result_t;

endpackage

/* rtl/api_frame_receive_parser_top.sv */
// API frame receive parser: start hunt, header capture, payload stream, checksum report.
//
// Input stream s_*: one received serial byte per word in s_tdata[7:0].
// Output stream m_*: m_tuser is the kind (0 payload byte, 1 frame-end report),
// m_tdata carries the payload byte, status, header fields, addressed flag and
// the good and error frame counters.
// Config channel cfg_*: cfg_index 0 own address, 1 broadcast address,
// 2 hunt limit; cfg_ready is always high. Write only while the block is idle.
// Each accepted byte is parsed in the cycle it is taken; its result, if any, is
// registered in the output register, or in the skid register if that one is held.
// Throughput is one byte per cycle: the parser state machine takes a byte
// every clock, and a two-entry output buffer (output register plus skid
// register) keeps s_tready high while only the output register is held.
// With the skid register full, s_tready is low until the receiver takes a word.
// Reset (rst_n low, asynchronous) returns the parser to start hunting, clears
// counters and header fields, empties the output buffer and restores the
// configuration registers to own 0, broadcast 255, hunt limit 6.
module api_frame_receive_parser_top
    import afrp_pkg::*;
#(
    parameter int unsigned MAX_DATA = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,    // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] payload_byte, [9:8] status, [17:10] instruction, [25:18] slave_address,
    // [41:26] source_address, [49:42] rssi, [57:50] options, [58] addressed_to_me,
    // [74:59] good_frames, [90:75] error_frames, [95:91] zero
    output logic [TDATA_W-1:0]     m_tdata,
    output logic                   m_tuser,    // [0] kind
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    localparam logic [15:0] MinLen = 16'(HEADER_LEN);
    localparam logic [15:0] MaxLen = 16'(MAX_DATA + HEADER_LEN);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_LEN_HI  = 4'd1,
        PH_LEN_LO  = 4'd2,
        PH_TYPE    = 4'd3,
        PH_SKIP    = 4'd4,
        PH_SRC_HI  = 4'd5,
        PH_SRC_LO  = 4'd6,
        PH_RSSI    = 4'd7,
        PH_OPT     = 4'd8,
        PH_INSTR   = 4'd9,
        PH_SLAVE   = 4'd10,
        PH_PAYLOAD = 4'd11,
        PH_CHECK   = 4'd12
    } phase_t;

    // configuration
    logic [7:0] own_addr_reg;
    logic [7:0] bcast_addr_reg;
    logic [7:0] hunt_limit_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [15:0] held_source_reg, held_source_next;
    logic [7:0]  held_rssi_reg, held_rssi_next;
    logic [7:0]  held_options_reg, held_options_next;
    logic [7:0]  held_instr_reg, held_instr_next;
    logic [7:0]  held_slave_reg, held_slave_next;
    logic [7:0]  stray_count_reg, stray_count_next;
    logic [15:0] good_count_reg, good_count_next;
    logic [15:0] error_count_reg, error_count_next;

    // output buffer
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    logic       in_take;
    logic       out_take;
    logic [7:0] rx_byte;
    logic       res_valid;
    logic       res_header;
    status_t    res_status;
    kind_t      res_kind;
    result_t    res;
    logic [7:0] stray_sum;
    logic [7:0] expect_sum;
    logic [15:0] good_inc;
    logic [15:0] error_inc;
    logic       addressed;

    assign s_tready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign in_take   = s_tvalid && s_tready;
    assign out_take  = m_tvalid && m_tready;
    assign rx_byte   = s_tdata;

    assign stray_sum  = stray_count_reg + 8'd1;
    assign expect_sum = SUM_BASE - running_sum_reg;
    assign good_inc   = (good_count_reg == 16'hFFFF) ? good_count_reg : good_count_reg + 16'd1;
    assign error_inc  = (error_count_reg == 16'hFFFF) ? error_count_reg : error_count_reg + 16'd1;
    assign addressed  = (held_slave_reg == own_addr_reg) || (held_slave_reg == bcast_addr_reg);

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        bytes_left_next   = bytes_left_reg;
        running_sum_next  = running_sum_reg;
        held_source_next  = held_source_reg;
        held_rssi_next    = held_rssi_reg;
        held_options_next = held_options_reg;
        held_instr_next   = held_instr_reg;
        held_slave_next   = held_slave_reg;
        stray_count_next  = stray_count_reg;
        good_count_next   = good_count_reg;
        error_count_next  = error_count_reg;
        res_valid         = 1'b0;
        res_header        = 1'b0;
        res_status        = ST_OK;
        res_kind          = KIND_REPORT;

        if (in_take)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        stray_count_next  = 8'd0;
                        frame_length_next = 16'd0;
                        held_source_next  = 16'd0;
                        held_rssi_next    = 8'd0;
                        held_options_next = 8'd0;
                        held_instr_next   = 8'd0;
                        held_slave_next   = 8'd0;
                        phase_next        = PH_LEN_HI;
                    end
                    else if (stray_sum >= hunt_limit_reg)
                    begin
                        stray_count_next = 8'd0;
                        error_count_next = error_inc;
                        res_valid        = 1'b1;
                        res_status       = ST_NOSTART;
                    end
                    else
                    begin
                        stray_count_next = stray_sum;
                    end
                end
                PH_LEN_HI:
                begin
                    frame_length_next = {rx_byte, 8'd0};
                    phase_next        = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    frame_length_next = {frame_length_reg[15:8], rx_byte};
                    phase_next        = PH_TYPE;
                end
                PH_TYPE:
                begin
                    if (rx_byte == STATUS_TYPE)
                    begin
                        bytes_left_next = 8'd3;
                        phase_next      = PH_SKIP;
                    end
                    else if (frame_length_reg < MinLen || frame_length_reg > MaxLen)
                    begin
                        phase_next       = PH_HUNT;
                        error_count_next = error_inc;
                        res_valid        = 1'b1;
                        res_status       = ST_LENGTH;
                    end
                    else
                    begin
                        running_sum_next = rx_byte;
                        phase_next       = PH_SRC_HI;
                    end
                end
                PH_SKIP:
                begin
                    bytes_left_next = bytes_left_reg - 8'd1;
                    if (bytes_left_reg == 8'd1)
                        phase_next = PH_HUNT;
                end
                PH_SRC_HI:
                begin
                    held_source_next = {rx_byte, 8'd0};
                    running_sum_next = running_sum_reg + rx_byte;
                    phase_next       = PH_SRC_LO;
                end
                PH_SRC_LO:
                begin
                    held_source_next = {held_source_reg[15:8], rx_byte};
                    running_sum_next = running_sum_reg + rx_byte;
                    phase_next       = PH_RSSI;
                end
                PH_RSSI:
                begin
                    held_rssi_next   = rx_byte;
                    running_sum_next = running_sum_reg + rx_byte;
                    phase_next       = PH_OPT;
                end
                PH_OPT:
                begin
                    held_options_next = rx_byte;
                    running_sum_next  = running_sum_reg + rx_byte;
                    phase_next        = PH_INSTR;
                end
                PH_INSTR:
                begin
                    held_instr_next  = rx_byte;
                    running_sum_next = running_sum_reg + rx_byte;
                    phase_next       = PH_SLAVE;
                end
                PH_SLAVE:
                begin
                    held_slave_next  = rx_byte;
                    running_sum_next = running_sum_reg + rx_byte;
                    // length was range checked, so the low byte holds it
                    bytes_left_next  = frame_length_reg[7:0] - 8'(HEADER_LEN);
                    phase_next       = (frame_length_reg[7:0] == 8'(HEADER_LEN)) ?
                                       PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    running_sum_next = running_sum_reg + rx_byte;
                    bytes_left_next  = bytes_left_reg - 8'd1;
                    if (bytes_left_reg == 8'd1)
                        phase_next = PH_CHECK;
                    res_valid  = 1'b1;
                    res_header = 1'b1;
                    res_kind   = KIND_PAYLOAD;
                end
                PH_CHECK:
                begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res_header = 1'b1;
                    if (expect_sum == rx_byte)
                    begin
                        good_count_next = good_inc;
                        res_status      = ST_OK;
                    end
                    else
                    begin
                        error_count_next = error_inc;
                        res_status       = ST_CHECKSUM;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        res.kind            = res_kind;
        res.payload_byte    = (res_kind == KIND_PAYLOAD) ? rx_byte : 8'd0;
        res.status          = res_status;
        res.instruction     = res_header ? held_instr_reg : 8'd0;
        res.slave_address   = res_header ? held_slave_reg : 8'd0;
        res.source_address  = res_header ? held_source_reg : 16'd0;
        res.rssi            = res_header ? held_rssi_reg : 8'd0;
        res.options         = res_header ? held_options_reg : 8'd0;
        res.addressed_to_me = res_header && addressed;
        res.good_frames     = good_count_next;
        res.error_frames    = error_count_next;
    end

    // output register with skid register behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg   <= OWN_ADDR_RESET;
            bcast_addr_reg <= BCAST_ADDR_RESET;
            hunt_limit_reg <= HUNT_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OWN_ADDR:   own_addr_reg   <= cfg_data;
                CFG_BCAST_ADDR: bcast_addr_reg <= cfg_data;
                CFG_HUNT_LIMIT: hunt_limit_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            frame_length_reg <= 16'd0;
            bytes_left_reg   <= 8'd0;
            running_sum_reg  <= 8'd0;
            held_source_reg  <= 16'd0;
            held_rssi_reg    <= 8'd0;
            held_options_reg <= 8'd0;
            held_instr_reg   <= 8'd0;
            held_slave_reg   <= 8'd0;
            stray_count_reg  <= 8'd0;
            good_count_reg   <= 16'd0;
            error_count_reg  <= 16'd0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            bytes_left_reg   <= bytes_left_next;
            running_sum_reg  <= running_sum_next;
            held_source_reg  <= held_source_next;
            held_rssi_reg    <= held_rssi_next;
            held_options_reg <= held_options_next;
            held_instr_reg   <= held_instr_next;
            held_slave_reg   <= held_slave_next;
            stray_count_reg  <= stray_count_next;
            good_count_reg   <= good_count_next;
            error_count_reg  <= error_count_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.kind;
    assign m_tdata  = {5'd0,
                       out_data_reg.error_frames,
                       out_data_reg.good_frames,
                       out_data_reg.addressed_to_me,
                       out_data_reg.options,
                       out_data_reg.rssi,
                       out_data_reg.source_address,
                       out_data_reg.slave_address,
                       out_data_reg.instruction,
                       out_data_reg.status,
                       out_data_reg.payload_byte};

    // skid entry only fills behind a held output word
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // a payload byte always produces a word
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && phase_reg == PH_PAYLOAD) |=> out_valid_reg)
        else $error("payload byte lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HUNT) |-> (stray_count_reg == 8'd0))
        else $error("stray count live outside hunt");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |->
            (bytes_left_reg == 8'd1 || bytes_left_reg == 8'd2 || bytes_left_reg == 8'd3))
        else $error("status frame skip count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (good_count_reg >= $past(good_count_reg)
                  && error_count_reg >= $past(error_count_reg)))
        else $error("frame counter went backward");

endmodule
